@@ hdl/rla_pkg.sv @@
// Shared types, codes and sizing constants of the link association engine.
`default_nettype none

package rla_pkg;

  // Outstanding packet table depth and ack acceptance window
  localparam int SLOTS = 4;
  localparam int WIN   = 3;
  localparam int CNT_W = $clog2(SLOTS + 1);

  // Register reset values and the syn backoff base factor
  localparam logic [7:0] PEER_RESET  = 8'd0;
  localparam logic [7:0] RETRY_RESET = 8'd15;
  localparam logic [3:0] SYN_FACTOR  = 4'd5;

  // Configuration register indexes
  localparam logic [7:0] CFG_PEER_ADDRESS = 8'd0;
  localparam logic [7:0] CFG_RETRY_LIMIT  = 8'd1;

  typedef enum logic [2:0] {
    CMD_ASSOCIATE    = 3'd0,
    CMD_DISASSOCIATE = 3'd1,
    CMD_SEND_DATA    = 3'd2,
    CMD_RECEIVE      = 3'd3,
    CMD_TICK         = 3'd4,
    CMD_ACK_TASK     = 3'd5,
    CMD_SHUTDOWN     = 3'd6
  } rla_cmd_e;

  typedef enum logic [2:0] {
    OP_SYN      = 3'd0,
    OP_SYN_ACK  = 3'd1,
    OP_COMPLETE = 3'd2,
    OP_DISASSOC = 3'd3,
    OP_DATA     = 3'd4,
    OP_ACK      = 3'd5,
    OP_KEY_EXCH = 3'd6
  } rla_op_e;

  typedef enum logic [2:0] {
    LINK_CLOSED        = 3'd0,
    LINK_CONNECTING    = 3'd1,
    LINK_CONN_COMPLETE = 3'd2,
    LINK_CONNECTED     = 3'd3,
    LINK_CLOSING       = 3'd4
  } rla_link_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_WRITABLE = 3'd1,
    EV_READABLE = 3'd2,
    EV_HANG_UP  = 3'd3,
    EV_FAULT    = 3'd4
  } rla_event_e;

  typedef enum logic [1:0] {
    TMR_LEAVE = 2'd0,
    TMR_START = 2'd1,
    TMR_STOP  = 2'd2
  } rla_timer_e;

  // Unacknowledged packet table, valid slots packed from slot 0, oldest first
  typedef struct packed {
    logic [SLOTS-1:0]       valid;
    logic [SLOTS-1:0][7:0]  seq;
    logic [SLOTS-1:0][7:0]  retries;
  } rla_table_t;

  typedef struct packed {
    rla_link_e   conn;
    logic [7:0]  seq_num;
    logic [7:0]  ack_num;
    logic [7:0]  pending;
    logic [7:0]  peer_isn;
    rla_table_t  tbl;
  } rla_state_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  rx_from;
    logic [2:0]  rx_op;
    logic [7:0]  rx_seq;
    logic [7:0]  rx_ack;
    logic [7:0]  random_value;
  } rla_item_t;

  typedef struct packed {
    logic        send;
    logic        resend;
    rla_op_e     op;
    logic [7:0]  seq;
    logic [7:0]  ack;
    logic        deliver;
    logic        status;
    rla_event_e  event_code;
    rla_timer_e  treq;
    logic [3:0]  tfac;
    rla_link_e   link;
  } rla_result_t;

endpackage

`default_nettype wire

@@ hdl/rla_decide.sv @@
// Decision logic: next association state and the result for one item.
`default_nettype none

module rla_decide import rla_pkg::*; (
  input  rla_state_t  state_i,
  input  rla_item_t   item_i,
  input  logic [7:0]  peer_i,
  input  logic [7:0]  limit_i,
  output rla_state_t  state_o,
  output rla_result_t result_o
);

  typedef struct packed {
    rla_state_t  st;
    rla_result_t res;
  } ctx_t;

  // True when b lies within the ack window below a, modulo 256
  function automatic logic in_ack_window(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = a - b;
    return d < 8'(WIN);
  endfunction

  // Byte modulo five: 16 is one modulo five, so fold the nibbles first
  function automatic logic [2:0] mod5(input logic [7:0] x);
    logic [4:0] s;
    s = 5'(x[7:4]) + 5'(x[3:0]);
    if (s >= 5'd20) s = s - 5'd20;
    if (s >= 5'd10) s = s - 5'd10;
    if (s >= 5'd5) s = s - 5'd5;
    return s[2:0];
  endfunction

  // Store a sequence id in the first free slot; drop it when full
  function automatic rla_table_t push(input rla_table_t t, input logic [7:0] id,
                                      input logic [7:0] limit);
    rla_table_t r;
    logic       done;
    r    = t;
    done = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!done && !r.valid[i]) begin
        r.valid[i]   = 1'b1;
        r.seq[i]     = id;
        r.retries[i] = limit;
        done         = 1'b1;
      end
    end
    return r;
  endfunction

  // Send a header, folding pending acks into the ack number; headers other than ack and syn-ack enter the table
  function automatic ctx_t emit(input ctx_t c, input rla_op_e op, input logic [7:0] limit);
    ctx_t r;
    r             = c;
    r.st.ack_num  = r.st.ack_num + r.st.pending;
    r.st.pending  = 8'd0;
    r.res.send    = 1'b1;
    r.res.op      = op;
    r.res.seq     = r.st.seq_num;
    r.res.ack     = r.st.ack_num;
    if (op == OP_SYN_ACK) begin
      r.res.seq = r.st.seq_num + 8'd1;
      r.res.ack = r.st.peer_isn;
    end else if (op != OP_ACK) begin
      r.st.tbl = push(r.st.tbl, r.st.seq_num, limit);
    end
    return r;
  endfunction

  // Start the timer on an empty table, advance the sequence and send
  function automatic ctx_t send_op(input ctx_t c, input rla_op_e op, input logic [7:0] rnd,
                                   input logic [7:0] limit);
    ctx_t r;
    r = c;
    if (!r.st.tbl.valid[0]) begin
      r.res.treq = TMR_START;
      r.res.tfac = (op == OP_SYN) ? SYN_FACTOR + 4'(mod5(rnd)) : 4'd1;
    end
    r.st.seq_num = r.st.seq_num + 8'd1;
    return emit(r, op, limit);
  endfunction

  function automatic ctx_t associate(input ctx_t c, input logic [7:0] rnd,
                                     input logic [7:0] limit);
    ctx_t r;
    r            = c;
    r.st.conn    = LINK_CONNECTING;
    r.st.ack_num = 8'd0;
    return send_op(r, OP_SYN, rnd, limit);
  endfunction

  rla_table_t             ack_tbl;
  logic                   ack_freed;
  logic                   ack_empty;
  logic [SLOTS-1:0]       keep;
  logic [CNT_W-1:0]       rank [SLOTS];
  logic [CNT_W-1:0]       running;
  ctx_t                   c;
  rla_cmd_e               cmd;
  rla_op_e                rop;
  logic [7:0]             rs;
  logic [7:0]             ra;
  logic [7:0]             rnd;

  assign cmd = rla_cmd_e'(item_i.command);
  assign rop = rla_op_e'(item_i.rx_op);
  assign rs  = item_i.rx_seq;
  assign ra  = item_i.rx_ack;
  assign rnd = item_i.random_value;

  // Free slots acknowledged by rx_ack and compact the survivors
  always_comb begin
    keep      = '0;
    ack_freed = 1'b0;
    running   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (state_i.tbl.valid[i]) begin
        if (in_ack_window(ra, state_i.tbl.seq[i])) ack_freed = 1'b1;
        else keep[i] = 1'b1;
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      rank[i] = running;
      if (keep[i]) running = running + CNT_W'(1);
    end
    ack_tbl       = state_i.tbl;
    ack_tbl.valid = '0;
    for (int j = 0; j < SLOTS; j++) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (keep[i] && rank[i] == CNT_W'(j)) begin
          ack_tbl.seq[j]     = state_i.tbl.seq[i];
          ack_tbl.retries[j] = state_i.tbl.retries[i];
          ack_tbl.valid[j]   = 1'b1;
        end
      end
    end
    ack_empty = (keep == '0);
  end

  // Walk the command and update state and result
  always_comb begin
    c.st          = state_i;
    c.res         = '0;
    c.res.tfac    = 4'd1;
    unique case (cmd)
      CMD_ASSOCIATE: c = associate(c, rnd, limit_i);
      CMD_DISASSOCIATE: begin
        c         = send_op(c, OP_DISASSOC, rnd, limit_i);
        c.st.conn = LINK_CLOSING;
      end
      CMD_SEND_DATA: begin
        if (c.st.conn != LINK_CONNECTED) c.res.status = 1'b1;
        else c = send_op(c, OP_DATA, rnd, limit_i);
      end
      CMD_RECEIVE: begin
        if (item_i.rx_from != peer_i) begin
          c.res.status = 1'b1;
        end else begin
          unique case (rop)
            OP_SYN: begin
              if (ra != 8'd0) begin
                c.res.status = 1'b1;
              end else begin
                c.st.peer_isn = rs;
                c = emit(c, OP_SYN_ACK, limit_i);
              end
            end
            OP_COMPLETE: begin
              if (ra == c.st.seq_num + 8'd1 && rs == c.st.peer_isn + 8'd1) begin
                c.st.tbl.valid = '0;
                c.res.treq     = TMR_STOP;
                c.st.seq_num   = c.st.seq_num + 8'd1;
                c.st.peer_isn  = 8'd0;
                c.st.ack_num   = rs;
                if (c.st.conn != LINK_CONNECTED) begin
                  c.st.conn        = LINK_CONNECTED;
                  c.res.event_code = EV_WRITABLE;
                end
                c = emit(c, OP_ACK, limit_i);
              end else if (rs == c.st.ack_num) begin
                c = emit(c, OP_ACK, limit_i);
              end else begin
                c.res.status = 1'b1;
              end
            end
            OP_SYN_ACK: begin
              if (c.st.conn != LINK_CONNECTING || ra != c.st.seq_num) begin
                c.res.status = 1'b1;
              end else begin
                c.st.tbl = ack_tbl;
                if (ack_empty) c.res.treq = TMR_STOP;
                if (!ack_freed) begin
                  c.res.status = 1'b1;
                end else begin
                  c.st.conn    = LINK_CONN_COMPLETE;
                  c.st.ack_num = rs;
                  c = send_op(c, OP_COMPLETE, rnd, limit_i);
                end
              end
            end
            OP_ACK: begin
              c.st.tbl = ack_tbl;
              if (ack_empty) c.res.treq = TMR_STOP;
              if (!ack_freed) begin
                c.res.status = 1'b1;
              end else if (c.st.conn == LINK_CLOSING) begin
                c.st.conn        = LINK_CLOSED;
                c.res.event_code = EV_HANG_UP;
              end else if (c.st.conn == LINK_CONN_COMPLETE) begin
                c.st.conn        = LINK_CONNECTED;
                c.res.event_code = EV_WRITABLE;
              end
            end
            OP_DATA: begin
              if (c.st.conn != LINK_CONNECTED && c.st.conn != LINK_CLOSING) begin
                c.res.status = 1'b1;
              end else begin
                c.st.tbl = ack_tbl;
                if (ack_empty) c.res.treq = TMR_STOP;
                if (in_ack_window(c.st.ack_num + c.st.pending, rs)) begin
                  c = emit(c, OP_ACK, limit_i);
                end else begin
                  c.st.pending     = c.st.pending + 8'd1;
                  c.res.deliver    = 1'b1;
                  c.res.event_code = EV_READABLE;
                end
              end
            end
            OP_DISASSOC: begin
              c.st.tbl = ack_tbl;
              if (ack_empty) c.res.treq = TMR_STOP;
              if ((rs == c.st.ack_num && c.st.conn == LINK_CLOSED) ||
                  in_ack_window(c.st.ack_num + c.st.pending, rs)) begin
                c = emit(c, OP_ACK, limit_i);
              end else begin
                c.st.pending = c.st.pending + 8'd1;
                if (c.st.conn == LINK_CONNECTED) c.st.conn = LINK_CLOSED;
                c.res.event_code = EV_HANG_UP;
                c = emit(c, OP_ACK, limit_i);
              end
            end
            default: c.res.status = 1'b1;
          endcase
        end
      end
      CMD_TICK: begin
        if (!c.st.tbl.valid[0]) begin
          if (c.st.conn == LINK_CONNECTING) c = send_op(c, OP_SYN, rnd, limit_i);
          else if (c.st.conn == LINK_CLOSING) c = send_op(c, OP_DISASSOC, rnd, limit_i);
          else if (c.st.conn == LINK_CONN_COMPLETE) c = send_op(c, OP_COMPLETE, rnd, limit_i);
        end else if (c.st.tbl.retries[0] == 8'd0) begin
          // Retries exhausted: drop the table, flag error, restart association
          c.st.tbl.valid   = '0;
          c.res.treq       = TMR_STOP;
          c.res.event_code = EV_FAULT;
          c = associate(c, rnd, limit_i);
        end else begin
          c.st.tbl.retries[0] = c.st.tbl.retries[0] - 8'd1;
          c.res.send   = 1'b1;
          c.res.resend = 1'b1;
          c.res.seq    = c.st.tbl.seq[0];
          c.res.treq   = TMR_START;
          c.res.tfac   = 4'd1;
        end
      end
      CMD_ACK_TASK: begin
        if (c.st.pending != 8'd0) c = emit(c, OP_ACK, limit_i);
      end
      CMD_SHUTDOWN: begin
        c.st.conn      = LINK_CLOSED;
        c.st.tbl.valid = '0;
        c.res.treq     = TMR_STOP;
      end
      default: c.res.status = 1'b1;
    endcase
    c.res.link = c.st.conn;
  end

  assign state_o  = c.st;
  assign result_o = c.res;

endmodule

`default_nettype wire

@@ hdl/reliable_link_association_engine.sv @@
// Top level of the link association engine: stream ports, state and result registers.
`default_nettype none

// Association engine for one peer of a reliable datagram link. Each transfer
// on the slave stream is one command or received header (command in tuser);
// each produces exactly one decision transfer on the master stream. The block
// sustains one item per clock while the master side is ready: an input register
// feeds the decision logic, which updates the association state and loads the
// result register in the same cycle; a result leaves the result register when
// the master side is ready. The state update loop closes through the decision
// logic. Both registers hold under backpressure. There is no clearing pass
// after reset. Configuration writes (peer address, retry limit) are taken
// every cycle and belong to idle time.
module reliable_link_association_engine import rla_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // rx_from[7:0], rx_op[10:8], rx_seq[18:11], rx_ack[26:19], random_value[34:27]
  input  logic [39:0] s_axis_tdata,
  // command[2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tx_send[0], tx_resend[1], tx_op[4:2], tx_seq[12:5], tx_ack[20:13],
  // deliver[21], status[22], event_code[25:23], timer_request[27:26],
  // timer_factor[31:28], link_state[34:32]
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic        in_valid_q;
  rla_item_t   item_q;
  logic        out_valid_q;
  rla_result_t res_q;
  rla_state_t  state_q;
  rla_state_t  state_d;
  rla_result_t res_d;
  logic [7:0]  peer_q;
  logic [7:0]  limit_q;
  logic        advance;

  // Result register frees when empty or taken
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  // Capture the input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.command      <= s_axis_tuser[2:0];
      item_q.rx_from      <= s_axis_tdata[7:0];
      item_q.rx_op        <= s_axis_tdata[10:8];
      item_q.rx_seq       <= s_axis_tdata[18:11];
      item_q.rx_ack       <= s_axis_tdata[26:19];
      item_q.random_value <= s_axis_tdata[34:27];
    end
  end

  rla_decide u_decide (
    .state_i  (state_q),
    .item_i   (item_q),
    .peer_i   (peer_q),
    .limit_i  (limit_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Commit state and load the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peer_q  <= PEER_RESET;
      limit_q <= RETRY_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_PEER_ADDRESS) peer_q <= cfg_data_i;
      else if (cfg_index_i == CFG_RETRY_LIMIT) limit_q <= cfg_data_i;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, res_q.link, res_q.tfac, res_q.treq, res_q.event_code,
                          res_q.status, res_q.deliver, res_q.ack, res_q.seq, res_q.op,
                          res_q.resend, res_q.send};

  // Valid slots stay packed from slot 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q.tbl.valid + SLOTS'(1)) & state_q.tbl.valid) == '0)
    else $error("outstanding table not packed");

  // A decision always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("decision lost");

  // A resend is always a send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.resend |-> res_q.send)
    else $error("resend without send");

  // Backoff factor only with a started syn timer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_q.tfac != 4'd1 |-> res_q.treq == TMR_START && res_q.op == OP_SYN)
    else $error("backoff factor without syn timer start");

endmodule

`default_nettype wire
